// File: rtl/lik_pkg.sv
// ----------------------------------------------------------------------------
// Leg inverse kinematics package
// Shared widths, codes, angle constants and step functions for the IK pipe.
// ----------------------------------------------------------------------------
package lik_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 25;
    localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    localparam int LEG_W   = 3;
    localparam int COORD_W = 16;
    localparam int LEN_W   = 16;
    localparam int TRIM_W  = 48;
    localparam int AUTO_W  = 2;
    localparam int IDX_W   = 3;
    localparam int DEG_W   = 8;
    localparam int STAT_W  = 2;
    localparam int ANG_W   = 20;
    localparam int SQ_W    = 52;

    localparam logic [LEG_W-1:0] LEG_LAST = LEG_W'(5);
    localparam logic [DEG_W-1:0] DEG_MAX  = DEG_W'(180);

    // angles in 1/256 degree
    localparam logic signed [ANG_W-1:0] A_23    = ANG_W'(23 * 256);
    localparam logic signed [ANG_W-1:0] A_45    = ANG_W'(45 * 256);
    localparam logic signed [ANG_W-1:0] A_90    = ANG_W'(90 * 256);
    localparam logic signed [ANG_W-1:0] A_104   = ANG_W'((90 + 14) * 256);
    localparam logic signed [ANG_W-1:0] A_135   = ANG_W'(135 * 256);
    localparam logic signed [ANG_W-1:0] A_180   = ANG_W'(180 * 256);
    localparam logic signed [ANG_W-1:0] A_225   = ANG_W'(225 * 256);
    localparam logic signed [ANG_W-1:0] A_270   = ANG_W'(270 * 256);
    localparam logic signed [ANG_W-1:0] A_315   = ANG_W'(315 * 256);

    localparam logic [13:0] ATAN_TAB [ATAN_LEN] = '{
        14'd11520, 14'd6801, 14'd3593, 14'd1824, 14'd916, 14'd458, 14'd229,
        14'd115, 14'd57, 14'd29, 14'd14, 14'd7, 14'd4, 14'd2, 14'd1,
        14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0
    };

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_REACH  = 2'd1,
        STAT_MANUAL = 2'd2
    } t_status;

    typedef enum logic [IDX_W-1:0] {
        REG_COXA_LEN   = 3'd0,
        REG_FEMUR_LEN  = 3'd1,
        REG_TIBIA_LEN  = 3'd2,
        REG_COXA_TRIM  = 3'd3,
        REG_FEMUR_TRIM = 3'd4,
        REG_TIBIA_TRIM = 3'd5,
        REG_AUTO_LEGS  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } t_sq;

    // one digit of the bitwise square root
    function automatic t_sq sq_step(input t_sq s, input logic [SQ_W-1:0] b);
        t_sq             o;
        logic [SQ_W-1:0] rb;
        rb = s.r + b;
        if (s.v >= rb) begin
            o.v = s.v - rb;
            o.r = (s.r >> 1) + b;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic logic signed [ANG_W-1:0] trim_sel(
        input logic [TRIM_W-1:0] trims, input logic [LEG_W-1:0] leg);
        logic [7:0] t;
        case (leg)
            0: t = trims[7:0];
            1: t = trims[15:8];
            2: t = trims[23:16];
            3: t = trims[31:24];
            4: t = trims[39:32];
            5: t = trims[47:40];
            default: t = '0;
        endcase
        return {{(ANG_W-16){t[7]}}, t, 8'b0};
    endfunction

    function automatic logic signed [ANG_W-1:0] mount_ofs(
        input logic [LEG_W-1:0] leg, input logic neg);
        logic signed [ANG_W-1:0] m;
        case (leg)
            0: m = A_45;
            1: m = A_90;
            2: m = A_135;
            3: m = neg ? A_225 : -A_135;
            4: m = neg ? A_270 : -A_90;
            default: m = neg ? A_315 : -A_45;
        endcase
        return m;
    endfunction

    function automatic logic [DEG_W-1:0] to_deg(input logic signed [ANG_W-1:0] a);
        logic [DEG_W-1:0] d;
        if (a < 0) begin
            d = '0;
        end else if (a > A_180) begin
            d = DEG_MAX;
        end else begin
            d = a[15:8];
        end
        return d;
    endfunction

endpackage

// File: rtl/lik_if.sv
// ----------------------------------------------------------------------------
// Leg inverse kinematics channels
// Target, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lik_in_if;
    import lik_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [LEG_W-1:0]          leg;
    logic signed [COORD_W-1:0] tgt_x;
    logic signed [COORD_W-1:0] tgt_y;
    logic signed [COORD_W-1:0] tgt_z;
    modport source(output valid, leg, tgt_x, tgt_y, tgt_z, input ready);
    modport sink(input valid, leg, tgt_x, tgt_y, tgt_z, output ready);
endinterface

interface lik_out_if;
    import lik_pkg::*;
    logic              valid;
    logic              ready;
    logic [LEG_W-1:0]  leg_out;
    logic [DEG_W-1:0]  hip_deg;
    logic [DEG_W-1:0]  thigh_deg;
    logic [DEG_W-1:0]  shin_deg;
    logic [STAT_W-1:0] status;
    modport source(output valid, leg_out, hip_deg, thigh_deg, shin_deg, status,
                   input ready);
    modport sink(input valid, leg_out, hip_deg, thigh_deg, shin_deg, status,
                 output ready);
endinterface

interface lik_cfg_if;
    import lik_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [TRIM_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// Leg inverse kinematics
// Foot target to coxa/femur/tibia servo angles, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  i_in takes one word per cycle unless o_out stalls: leg number and foot target x, y, z.
//  o_out returns one word per target, in order: leg, three servo angles
//  in whole degrees and a status (written, out of reach, manual leg).
//  i_cfg writes the segment lengths, per-leg trims and the auto-leg mask;
//  it is always ready; the user must write it only while the pipe is
//  empty, and the block itself does not enforce this. Three bitwise
//  square roots (24, 25 and 17 digit stages), a 16-stage restoring
//  divider, a 5-stage normalizer and the CORDIC vectoring stages set
//  the depth. Throughput is one word per cycle while o_out is not
//  stalled.
//  When o_out is stalled with a word waiting, the whole pipe holds and
//  i_in.ready drops; bubbles still advance while the last stage is empty.
//  Reset empties the pipe and loads the register defaults (lengths and
//  trims zero, both auto legs on kinematic control).
// ----------------------------------------------------------------------------
module leg_inverse_kinematics (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lik_in_if.sink    i_in,
    lik_out_if.source o_out,
    lik_cfg_if.sink   i_cfg
);
    import lik_pkg::*;

    localparam int K1 = 24;
    localparam int K2 = 25;
    localparam int K3 = 17;
    localparam int DIV_N  = 16;
    localparam int NORM_N = 5;

    localparam int PS_SQA = 1;
    localparam int PS_SQB = 2;
    localparam int PS_R1  = 3;
    localparam int PS_L0  = PS_R1 + K1;
    localparam int PS_L3A = PS_L0 + 1;
    localparam int PS_L3B = PS_L3A + 1;
    localparam int PS_R2  = PS_L3B + 1;
    localparam int PS_M   = PS_R2 + K2;
    localparam int PS_N   = PS_M + 1;
    localparam int PS_S   = PS_N + 1;
    localparam int PS_DV  = PS_S + 1;
    localparam int PS_C   = PS_DV + DIV_N;
    localparam int PS_C2  = PS_C + 1;
    localparam int PS_C3  = PS_C2 + 1;
    localparam int PS_R3  = PS_C3 + 1;
    localparam int PS_CI  = PS_R3 + K3;
    localparam int PS_NM  = PS_CI + 1;
    localparam int PS_F   = PS_NM + NORM_N;
    localparam int PS_CR  = PS_F + 1;
    localparam int PS_A   = PS_CR + CORDIC_N;
    localparam int D      = PS_A + 1;

    typedef struct packed {
        logic [LEG_W-1:0]          leg;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic signed [COORD_W-1:0] tz;
        t_status                   status;
        logic [49:0]               p0;
        logic [49:0]               p1;
        t_sq                       sq0;
        t_sq                       sq1;
        logic signed [24:0]        l0;
        logic signed [23:0]        z8;
        logic [24:0]               l3;
        logic [31:0]               ff;
        logic [31:0]               tt;
        logic [31:0]               ft;
        logic [49:0]               ll;
        logic [40:0]               fl;
        logic [1:0][SQ_W-1:0]      num;
        logic [1:0][SQ_W-1:0]      den;
        logic [1:0][SQ_W-1:0]      rem;
        logic [1:0]                neg;
        logic [1:0]                sat;
        logic [1:0][15:0]          quot;
        logic [1:0][17:0]          c;
        logic [1:0][32:0]          csq;
        logic [3:0][32:0]          cx;
        logic [3:0][32:0]          cy;
        logic [3:0][ANG_W-1:0]     ang;
        logic signed [ANG_W-1:0]   hip;
        logic signed [ANG_W-1:0]   thigh;
        logic signed [ANG_W-1:0]   shin;
        logic [DEG_W-1:0]          hd;
        logic [DEG_W-1:0]          td;
        logic [DEG_W-1:0]          sd;
    } t_pl;

    logic [LEN_W-1:0]  r_coxa_len, r_femur_len, r_tibia_len;
    logic [TRIM_W-1:0] r_coxa_trim, r_femur_trim, r_tibia_trim;
    logic [AUTO_W-1:0] r_auto_legs;

    logic [D:0] r_vld;
    t_pl        r_pl [0:D];
    t_pl        n_pl [1:D];
    t_pl        n_pl0;
    logic       w_en;
    logic       w_acc;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coxa_len   <= '0;
            r_femur_len  <= '0;
            r_tibia_len  <= '0;
            r_coxa_trim  <= '0;
            r_femur_trim <= '0;
            r_tibia_trim <= '0;
            r_auto_legs  <= '1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_COXA_LEN:   r_coxa_len   <= i_cfg.data[LEN_W-1:0];
                REG_FEMUR_LEN:  r_femur_len  <= i_cfg.data[LEN_W-1:0];
                REG_TIBIA_LEN:  r_tibia_len  <= i_cfg.data[LEN_W-1:0];
                REG_COXA_TRIM:  r_coxa_trim  <= i_cfg.data;
                REG_FEMUR_TRIM: r_femur_trim <= i_cfg.data;
                REG_TIBIA_TRIM: r_tibia_trim <= i_cfg.data;
                REG_AUTO_LEGS:  r_auto_legs  <= i_cfg.data[AUTO_W-1:0];
                default: ;
            endcase
        end
    end

    // hold the whole pipe only when the output word is stalled
    assign w_en       = !r_vld[D] || o_out.ready;
    assign w_acc      = i_in.valid && w_en;
    assign i_in.ready = w_en;

    always_comb begin
        n_pl0     = '0;
        n_pl0.leg = i_in.leg;
        n_pl0.tx  = i_in.tgt_x;
        n_pl0.ty  = i_in.tgt_y;
        n_pl0.tz  = i_in.tgt_z;
    end

    for (genvar k = 1; k <= D; k++) begin : g_st
        always_comb begin : c_st
            t_pl                     p;
            t_pl                     n;
            logic signed [31:0]      sx, sy;
            logic [31:0]             s32;
            logic signed [49:0]      l0sq;
            logic signed [47:0]      z8sq;
            logic [24:0]             l3;
            logic [16:0]             win_sum;
            logic signed [16:0]      win_dif;
            logic                    bad, manual;
            logic [32:0]             fftt;
            logic signed [32:0]      ffmt;
            logic [SQ_W-1:0]         mag, rem2;
            logic signed [17:0]      cc;
            logic signed [35:0]      csq;
            logic [32:0]             one_m;
            logic signed [32:0]      ax, ay, xs, ys, lim;
            logic signed [ANG_W-1:0] hip0;
            p = r_pl[k-1];
            n = p;
            sx = '0; sy = '0; s32 = '0; l0sq = '0; z8sq = '0; l3 = '0;
            win_sum = '0; win_dif = '0; bad = 1'b0; manual = 1'b0;
            fftt = '0; ffmt = '0; mag = '0; rem2 = '0; cc = '0; csq = '0;
            one_m = '0; ax = '0; ay = '0; xs = '0; ys = '0; lim = '0; hip0 = '0;

            if (k == PS_SQA) begin
                sx   = p.tx * p.tx;
                sy   = p.ty * p.ty;
                n.p0 = {18'b0, sx};
                n.p1 = {18'b0, sy};
            end else if (k == PS_SQB) begin
                s32      = p.p0[31:0] + p.p1[31:0];
                n.sq0.v  = {4'b0, s32, 16'b0};
                n.sq0.r  = '0;
            end else if (k >= PS_R1 && k < PS_R1 + K1) begin
                n.sq0 = sq_step(p.sq0, SQ_W'(1) << (2 * (K1 - 1 - (k - PS_R1))));
            end else if (k == PS_L0) begin
                n.l0 = $signed({1'b0, p.sq0.r[23:0]}) - $signed({1'b0, r_coxa_len, 8'b0});
                n.z8 = {p.tz, 8'b0};
            end else if (k == PS_L3A) begin
                l0sq = p.l0 * p.l0;
                z8sq = p.z8 * p.z8;
                n.p0 = l0sq;
                n.p1 = {2'b0, z8sq};
            end else if (k == PS_L3B) begin
                n.sq0.v = {2'b0, p.p0} + {2'b0, p.p1};
                n.sq0.r = '0;
            end else if (k >= PS_R2 && k < PS_R2 + K2) begin
                n.sq0 = sq_step(p.sq0, SQ_W'(1) << (2 * (K2 - 1 - (k - PS_R2))));
            end else if (k == PS_M) begin
                l3      = p.sq0.r[24:0];
                n.l3    = l3;
                n.ff    = r_femur_len * r_femur_len;
                n.tt    = r_tibia_len * r_tibia_len;
                n.ft    = r_femur_len * r_tibia_len;
                n.ll    = l3 * l3;
                n.fl    = r_femur_len * l3;
                win_sum = {1'b0, r_tibia_len} + {1'b0, r_femur_len};
                win_dif = $signed({1'b0, r_tibia_len}) - $signed({1'b0, r_femur_len});
                bad = !(l3 < {win_sum, 8'b0} &&
                        $signed({1'b0, l3}) > $signed({win_dif, 8'b0})) ||
                      r_femur_len == '0 || r_tibia_len == '0 || l3 == '0;
                manual = p.leg > LEG_LAST ||
                         (p.leg == '0 && !r_auto_legs[0]) ||
                         (p.leg == LEG_LAST && !r_auto_legs[1]);
                if (bad) begin
                    n.status = STAT_REACH;
                end else if (manual) begin
                    n.status = STAT_MANUAL;
                end else begin
                    n.status = STAT_OK;
                end
            end else if (k == PS_N) begin
                fftt     = {1'b0, p.ff} + {1'b0, p.tt};
                ffmt     = $signed({1'b0, p.ff}) - $signed({1'b0, p.tt});
                n.num[0] = {3'b0, fftt, 16'b0} - {2'b0, p.ll};
                n.num[1] = {{3{ffmt[32]}}, ffmt, 16'b0} + {2'b0, p.ll};
                n.den[0] = {3'b0, p.ft, 17'b0};
                n.den[1] = {2'b0, p.fl, 9'b0};
            end else if (k == PS_S) begin
                for (int i = 0; i < 2; i++) begin
                    mag       = p.num[i][SQ_W-1] ? (~p.num[i] + SQ_W'(1)) : p.num[i];
                    n.neg[i]  = p.num[i][SQ_W-1];
                    n.sat[i]  = mag >= p.den[i];
                    n.rem[i]  = mag;
                    n.quot[i] = '0;
                end
            end else if (k >= PS_DV && k < PS_DV + DIV_N) begin
                for (int i = 0; i < 2; i++) begin
                    rem2 = p.rem[i] << 1;
                    if (rem2 >= p.den[i]) begin
                        n.rem[i]  = rem2 - p.den[i];
                        n.quot[i] = {p.quot[i][14:0], 1'b1};
                    end else begin
                        n.rem[i]  = rem2;
                        n.quot[i] = {p.quot[i][14:0], 1'b0};
                    end
                end
            end else if (k == PS_C) begin
                for (int i = 0; i < 2; i++) begin
                    cc = p.sat[i] ? 18'sd65536 : $signed({2'b0, p.quot[i]});
                    if (p.neg[i]) begin
                        cc = -cc;
                    end
                    n.c[i] = cc;
                end
            end else if (k == PS_C2) begin
                for (int i = 0; i < 2; i++) begin
                    csq      = $signed(p.c[i]) * $signed(p.c[i]);
                    n.csq[i] = csq[32:0];
                end
            end else if (k == PS_C3) begin
                one_m   = 33'h1_0000_0000;
                n.sq0.v = (p.csq[0] >= one_m) ? '0 : {19'b0, one_m - p.csq[0]};
                n.sq1.v = (p.csq[1] >= one_m) ? '0 : {19'b0, one_m - p.csq[1]};
                n.sq0.r = '0;
                n.sq1.r = '0;
            end else if (k >= PS_R3 && k < PS_R3 + K3) begin
                n.sq0 = sq_step(p.sq0, SQ_W'(1) << (2 * (K3 - 1 - (k - PS_R3))));
                n.sq1 = sq_step(p.sq1, SQ_W'(1) << (2 * (K3 - 1 - (k - PS_R3))));
            end else if (k == PS_CI) begin
                // lanes: acos tibia, acos femur, atan2(z, l0), atan2(x, y)
                n.cx[0] = {{15{p.c[0][17]}}, p.c[0]};
                n.cy[0] = {16'b0, p.sq0.r[16:0]};
                n.cx[1] = {{15{p.c[1][17]}}, p.c[1]};
                n.cy[1] = {16'b0, p.sq1.r[16:0]};
                n.cx[2] = {{8{p.l0[24]}}, p.l0};
                n.cy[2] = {{9{p.z8[23]}}, p.z8};
                n.cx[3] = {{17{p.ty[15]}}, p.ty};
                n.cy[3] = {{17{p.tx[15]}}, p.tx};
                n.ang   = '0;
            end else if (k >= PS_NM && k < PS_NM + NORM_N) begin
                // scale up so the larger magnitude lands in [2^28, 2^29)
                lim = 33'sd1 <<< (29 - (16 >> (k - PS_NM)));
                for (int i = 0; i < 4; i++) begin
                    ax = p.cx[i][32] ? -$signed(p.cx[i]) : $signed(p.cx[i]);
                    ay = p.cy[i][32] ? -$signed(p.cy[i]) : $signed(p.cy[i]);
                    if ((ax | ay) < lim) begin
                        n.cx[i] = p.cx[i] << (16 >> (k - PS_NM));
                        n.cy[i] = p.cy[i] << (16 >> (k - PS_NM));
                    end
                end
            end else if (k == PS_F) begin
                for (int i = 0; i < 4; i++) begin
                    if (p.cx[i][32]) begin
                        n.ang[i] = p.cy[i][32] ? -A_180 : A_180;
                        n.cx[i]  = -$signed(p.cx[i]);
                        n.cy[i]  = -$signed(p.cy[i]);
                    end
                end
            end else if (k >= PS_CR && k < PS_CR + CORDIC_N) begin
                for (int i = 0; i < 4; i++) begin
                    xs = $signed(p.cx[i]) >>> (k - PS_CR);
                    ys = $signed(p.cy[i]) >>> (k - PS_CR);
                    if ($signed(p.cy[i]) > 0) begin
                        n.cx[i]  = $signed(p.cx[i]) + ys;
                        n.cy[i]  = $signed(p.cy[i]) - xs;
                        n.ang[i] = p.ang[i] + {6'b0, ATAN_TAB[k - PS_CR]};
                    end else if ($signed(p.cy[i]) < 0) begin
                        n.cx[i]  = $signed(p.cx[i]) - ys;
                        n.cy[i]  = $signed(p.cy[i]) + xs;
                        n.ang[i] = p.ang[i] - {6'b0, ATAN_TAB[k - PS_CR]};
                    end
                end
            end else if (k == PS_A) begin
                n.shin  = $signed(p.ang[0]) - A_23 + trim_sel(r_tibia_trim, p.leg);
                n.thigh = $signed(p.ang[1]) + $signed(p.ang[2]) + A_104
                        + trim_sel(r_femur_trim, p.leg);
                hip0    = $signed(p.ang[3]) + trim_sel(r_coxa_trim, p.leg);
                n.hip   = hip0 + mount_ofs(p.leg, hip0 < 0);
            end else begin
                // final stage: clamp, truncate, drop angles when not written
                if (p.status == STAT_OK) begin
                    n.hd = to_deg(p.hip);
                    n.td = to_deg(p.thigh);
                    n.sd = to_deg(p.shin);
                end else begin
                    n.hd = '0;
                    n.td = '0;
                    n.sd = '0;
                end
            end
            n_pl[k] = n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[D-1:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pl[0] <= n_pl0;
            for (int k = 1; k <= D; k++) begin
                r_pl[k] <= n_pl[k];
            end
        end
    end

    assign o_out.valid     = r_vld[D];
    assign o_out.leg_out   = r_pl[D].leg;
    assign o_out.hip_deg   = r_pl[D].hd;
    assign o_out.thigh_deg = r_pl[D].td;
    assign o_out.shin_deg  = r_pl[D].sd;
    assign o_out.status    = r_pl[D].status;

`ifndef NO_ASSERTIONS
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == STAT_OK |->
            o_out.hip_deg <= DEG_MAX && o_out.thigh_deg <= DEG_MAX &&
            o_out.shin_deg <= DEG_MAX)
        else $error("angle above 180 degrees on a written word");

    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != STAT_OK |->
            o_out.hip_deg == '0 && o_out.thigh_deg == '0 && o_out.shin_deg == '0)
        else $error("angles not cleared on an unwritten word");

    a_bad_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.leg_out > LEG_LAST |-> o_out.status != STAT_OK)
        else $error("invalid leg reported as written");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipe valid bits moved during a stall");
`endif

endmodule
